### design/olp_pkg.sv
// shared types and constants for the offset/label line parser
package olp_pkg;

   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0] SEP_RESET   = 8'h3a;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] DEC_DIGITS  = 8'h0a;
   localparam logic [CHAR_W-1:0] HEX_LETTERS = 8'h06;
   localparam logic [3:0]        HEX_LETTER_BASE = 4'ha;

   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMAL   = 1'b1;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_DIGIT = 3'd1,
      PH_GAP   = 3'd2,
      PH_LABEL = 3'd3,
      PH_TAIL  = 3'd4,
      PH_DROP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_byte;
      logic              end_of_line;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   label_byte;
      logic [OFFSET_W-1:0] symbol_offset;
      logic                record_done;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_W-1:0] separator_char;
      logic              decimal_mode;
   } cfg_type;

   typedef struct packed {
      phase_type           phase;
      logic [OFFSET_W-1:0] offset;
      logic                emit;
      rsp_type             rsp;
   } step_type;

endpackage

### design/olp_in_reg.sv
// request input register with stall generation
module olp_in_reg import olp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    advance,
   output logic    hold_valid,
   output req_type hold_payload
);

   logic    valid_ff;
   logic    valid_in;
   req_type payload_ff;
   logic    take;

   assign req_stall    = valid_ff && !advance;
   assign take         = req_valid && !req_stall;
   assign hold_valid   = valid_ff;
   assign hold_payload = payload_ff;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         payload_ff <= req_payload;
      end
   end

endmodule

### design/olp_step.sv
// per-character phase update, offset accumulation and result selection
module olp_step import olp_pkg::*; (
   input  cfg_type             cfg,
   input  phase_type           phase,
   input  logic [OFFSET_W-1:0] offset,
   input  req_type             req,
   output step_type            step
);

   logic [CHAR_W-1:0]   c;
   logic [CHAR_W-1:0]   num_rel;
   logic [CHAR_W-1:0]   up_rel;
   logic [CHAR_W-1:0]   low_rel;
   logic                is_blank;
   logic                is_digit;
   logic [3:0]          digit;
   logic [OFFSET_W-1:0] scaled;
   logic [OFFSET_W-1:0] next_offset;
   logic                is_sep;
   phase_type           digit_phase;

   assign c        = req.text_byte;
   assign num_rel  = c - CHAR_ZERO;
   assign up_rel   = c - CHAR_UPPER_A;
   assign low_rel  = c - CHAR_LOWER_A;
   assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign is_sep   = (c != CHAR_NUL) && (c == cfg.separator_char);

   always_comb begin
      is_digit = 1'b1;
      digit    = 4'd0;
      priority if (num_rel < DEC_DIGITS) begin
         digit = num_rel[3:0];
      end else if (cfg.decimal_mode) begin
         is_digit = 1'b0;
      end else if (up_rel < HEX_LETTERS) begin
         digit = HEX_LETTER_BASE + up_rel[3:0];
      end else if (low_rel < HEX_LETTERS) begin
         digit = HEX_LETTER_BASE + low_rel[3:0];
      end else begin
         is_digit = 1'b0;
      end
   end

   // times ten is eight plus two
   assign scaled = cfg.decimal_mode ? ((offset << 3) + (offset << 1)) : (offset << 4);
   assign next_offset = scaled + {{(OFFSET_W-4){1'b0}}, digit};

   always_comb begin
      if (is_digit) begin
         digit_phase = PH_DIGIT;
      end else if (is_sep) begin
         digit_phase = PH_GAP;
      end else begin
         digit_phase = PH_DROP;
      end
   end

   always_comb begin
      step.phase                 = phase;
      step.offset                = offset;
      step.emit                  = 1'b0;
      step.rsp.label_byte        = CHAR_NUL;
      step.rsp.symbol_offset     = '0;
      step.rsp.record_done       = 1'b0;
      if (req.end_of_line) begin
         step.phase  = PH_LEAD;
         step.offset = '0;
         if (phase == PH_GAP || phase == PH_LABEL || phase == PH_TAIL) begin
            step.emit              = 1'b1;
            step.rsp.symbol_offset = offset;
            step.rsp.record_done   = 1'b1;
         end
      end else begin
         unique case (phase)
            PH_LEAD, PH_DIGIT: begin
               if (!(phase == PH_LEAD && is_blank)) begin
                  step.phase = digit_phase;
                  if (is_digit) begin
                     step.offset = next_offset;
                  end
               end
            end
            PH_GAP, PH_LABEL: begin
               if (!(phase == PH_GAP && is_blank)) begin
                  if (is_blank || c == CHAR_NUL) begin
                     step.phase = PH_TAIL;
                  end else begin
                     step.phase          = PH_LABEL;
                     step.emit           = 1'b1;
                     step.rsp.label_byte = c;
                  end
               end
            end
            default: begin
               step.phase = phase;
            end
         endcase
      end
   end

endmodule

### design/olp_out_reg.sv
// response output register
module olp_out_reg import olp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_payload,
   output logic    load_ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type payload_ff;

   assign load_ready  = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= load_payload;
      end
   end

endmodule

### design/offset_label_line_parser_core.sv
// offset/label line parser top level
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_payload (text_byte, end_of_line)
//   rsp      out  rsp_valid/rsp_stall   rsp_payload (label_byte, symbol_offset, record_done)
//   csr      in   csr_wr_en             csr_index, csr_wdata
//
// one request per cycle unless stalled; emitting requests pass u_in_reg, then u_out_reg
// the parse step is one compare/shift-add layer between the input and output registers
// reset clears the phase, offset, valid flags and restores separator ':' and hex mode
// a stalled response holds an emitting request in the input register, which then stalls req
module offset_label_line_parser_core import olp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CHAR_W-1:0]    csr_wdata
);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   phase_type           phase_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                hold_valid;
   req_type             hold_payload;
   step_type            step;
   logic                load_ready;
   logic                advance;
   logic                load;

   assign advance = hold_valid && (!step.emit || load_ready);
   assign load    = advance && step.emit;

   olp_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .advance      (advance),
      .hold_valid   (hold_valid),
      .hold_payload (hold_payload)
   );

   olp_step u_step (
      .cfg    (cfg_ff),
      .phase  (phase_ff),
      .offset (offset_ff),
      .req    (hold_payload),
      .step   (step)
   );

   olp_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .load_payload (step.rsp),
      .load_ready   (load_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEPARATOR: cfg_in.separator_char = csr_wdata;
            CSR_DECIMAL:   cfg_in.decimal_mode   = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_char <= SEP_RESET;
         cfg_ff.decimal_mode   <= 1'b0;
         phase_ff              <= PH_LEAD;
         offset_ff             <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            phase_ff  <= step.phase;
            offset_ff <= step.offset;
         end
      end
   end

`ifndef ASSERT_OFF
   a_record_clears_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.record_done |-> rsp_payload.label_byte == CHAR_NUL)
      else $error("record carries a label byte");

   a_label_clears_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.record_done |-> rsp_payload.symbol_offset == '0)
      else $error("label response carries an offset");

   a_eol_restarts_line: assert property (@(posedge clock) disable iff (reset)
      advance && hold_payload.end_of_line |=> phase_ff == PH_LEAD && offset_ff == '0)
      else $error("end of line did not restart the parser");

   a_label_sets_phase: assert property (@(posedge clock) disable iff (reset)
      load && !step.rsp.record_done |=> phase_ff == PH_LABEL)
      else $error("label emitted outside label phase");

   a_no_load_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !load)
      else $error("response overwritten while stalled");
`endif

endmodule
